// ----- hdl/sbb_pkg.sv -----
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types and constants for the separable box blur: register indexes,
// the command word passed from front to back, and the queue geometry.
// ----------------------------------------------------------------------------
package sbb_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Widths fixed by the configuration registers
  localparam int DIM_W  = 11;
  localparam int RAD_W  = 4;
  // Ring slot numbers (window depth is at most 2*32+1)
  localparam int SLOT_W = 7;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One command: what the back has to do for one item
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              wr_en;    // store pixel into row window
    logic [SLOT_W-1:0] wr_slot;
    logic              h_en;     // run horizontal pass
    logic [DIM_W-1:0]  xq;
    logic [SLOT_W-1:0] hrow;     // line buffer row of the horizontal result
    logic [SLOT_W-1:0] hlo;      // first window slot of the horizontal box
    logic              v_en;     // run vertical pass and emit a pixel
    logic [DIM_W-1:0]  xo;
    logic [DIM_W-1:0]  yo;
    logic [SLOT_W-1:0] vlo;      // first line buffer row of the vertical box
    logic              eof;
    logic [RAD_W-1:0]  rad;
    logic [DIM_W-1:0]  wid;
    logic [DIM_W-1:0]  hgt;
  } cmd_t;

endpackage

// ----- hdl/sbb_front.sv -----
// ----------------------------------------------------------------------------
// sbb_front
// Holds configuration and frame position counters, classifies each item
// and issues a command for the back end.
// ----------------------------------------------------------------------------
module sbb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      flush,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic [7:0]                alpha,
  input  logic                      queue_full,
  output logic                      in_stall,
  output logic                      push,
  output sbb_pkg::cmd_t             cmd,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [sbb_pkg::DIM_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 16 * MAX_WIDTH + 17);
  localparam int SW = sbb_pkg::SLOT_W;
  localparam int DW = sbb_pkg::DIM_W;
  localparam int RW = sbb_pkg::RAD_W;

  logic [DW-1:0] cfg_w, cfg_h;
  logic [RW-1:0] cfg_r;
  logic [DW-1:0] wc, hc;
  logic [RW-1:0] rc;
  logic [NW-1:0] total, delay;
  logic [NW-1:0] n;
  logic [SW-1:0] nmod, yqm, yom;
  logic [DW-1:0] xq, xo, yo;
  logic          accept, ignore, wr, h_en, v_en, eof;
  logic [SW-1:0] rad2, hlo, vlo;

  // clamped configuration
  always_comb begin
    if (cfg_w == '0) wc = DW'(1);
    else if (32'(cfg_w) > MAX_WIDTH) wc = DW'(MAX_WIDTH);
    else wc = cfg_w;
    if (cfg_h == '0) hc = DW'(1);
    else if (32'(cfg_h) > MAX_HEIGHT) hc = DW'(MAX_HEIGHT);
    else hc = cfg_h;
    if (cfg_r == '0) rc = RW'(1);
    else if (32'(cfg_r) > MAX_RADIUS) rc = RW'(MAX_RADIUS);
    else rc = cfg_r;
  end

  assign total = NW'(wc) * NW'(hc);
  assign delay = NW'(rc) * NW'(wc) + NW'(rc);

  // classification of the current item
  assign ignore = (n < total) && flush;
  assign wr     = (n < total) && !flush;
  assign h_en   = (n >= NW'(rc)) && (n < total + NW'(rc));
  assign v_en   = (n >= delay);
  assign eof    = v_en && (xo == wc - DW'(1)) && (yo == hc - DW'(1));

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && !ignore && (wr || h_en || v_en);
  assign cfg_ready = 1'b1;

  // start slots of the two boxes, modulo the ring depth
  assign rad2 = SW'(rc) + SW'(rc);
  assign hlo  = (nmod >= rad2) ? nmod - rad2 : nmod + SW'(DEPTH) - rad2;
  assign vlo  = (yom >= SW'(rc)) ? yom - SW'(rc) : yom + SW'(DEPTH) - SW'(rc);

  always_comb begin
    cmd.red     = red;
    cmd.green   = green;
    cmd.blue    = blue;
    cmd.alpha   = alpha;
    cmd.wr_en   = wr;
    cmd.wr_slot = nmod;
    cmd.h_en    = h_en;
    cmd.xq      = xq;
    cmd.hrow    = yqm;
    cmd.hlo     = hlo;
    cmd.v_en    = v_en;
    cmd.xo      = xo;
    cmd.yo      = yo;
    cmd.vlo     = vlo;
    cmd.eof     = eof;
    cmd.rad     = rc;
    cmd.wid     = wc;
    cmd.hgt     = hc;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= DW'(640);
      cfg_h <= DW'(480);
      cfg_r <= RW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        sbb_pkg::REG_WIDTH:  cfg_w <= cfg_data;
        sbb_pkg::REG_HEIGHT: cfg_h <= cfg_data;
        sbb_pkg::REG_RADIUS: cfg_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && (cfg_index == sbb_pkg::REG_WIDTH ||
        cfg_index == sbb_pkg::REG_HEIGHT || cfg_index == sbb_pkg::REG_RADIUS)) ||
        (accept && !ignore && eof)) begin
      n    <= '0;
      nmod <= '0;
      xq   <= '0;
      yqm  <= '0;
      xo   <= '0;
      yo   <= '0;
      yom  <= '0;
    end else if (accept && !ignore) begin
      n    <= n + NW'(1);
      nmod <= (nmod == SW'(DEPTH - 1)) ? '0 : nmod + SW'(1);
      if (h_en) begin
        if (xq == wc - DW'(1)) begin
          xq  <= '0;
          yqm <= (yqm == SW'(DEPTH - 1)) ? '0 : yqm + SW'(1);
        end else begin
          xq <= xq + DW'(1);
        end
      end
      if (v_en) begin
        if (xo == wc - DW'(1)) begin
          xo  <= '0;
          yo  <= yo + DW'(1);
          yom <= (yom == SW'(DEPTH - 1)) ? '0 : yom + SW'(1);
        end else begin
          xo <= xo + DW'(1);
        end
      end
    end
  end

endmodule

// ----- hdl/sbb_queue.sv -----
// ----------------------------------------------------------------------------
// sbb_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sbb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbb_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sbb_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  sbb_pkg::cmd_t                   slots [sbb_pkg::QUEUE_DEPTH];
  logic [sbb_pkg::QPTR_W-1:0]      wptr, rptr;
  logic [sbb_pkg::QCNT_W-1:0]      count;

  assign full  = (count == sbb_pkg::QCNT_W'(sbb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + sbb_pkg::QPTR_W'(1);
      if (pop)  rptr <= rptr + sbb_pkg::QPTR_W'(1);
      if (push && !pop) count <= count + sbb_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - sbb_pkg::QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

endmodule

// ----- hdl/sbb_back.sv -----
// ----------------------------------------------------------------------------
// sbb_back
// Executes commands: row window update, horizontal box sum, line buffer
// write, vertical box sum over the line buffers, shared divider, output.
// ----------------------------------------------------------------------------
module sbb_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  sbb_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic          end_of_frame
);

  localparam int DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int WIN_IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACC_W  = 8 + CNT_W;
  localparam int DIV_CW = $clog2(ACC_W);
  localparam int MEM_AW = $clog2(DEPTH * MAX_WIDTH);
  localparam int SW     = sbb_pkg::SLOT_W;
  localparam int DW     = sbb_pkg::DIM_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HSUM  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_HWR   = 8'b0000_1000,
    S_VSUM  = 8'b0001_0000,
    S_VLAST = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t              state;
  sbb_pkg::cmd_t       cur;
  logic [31:0]         win [DEPTH];
  logic [31:0]         mem [DEPTH * MAX_WIDTH];
  logic [31:0]         rdata;
  logic                rd_pend;
  logic [ACC_W-1:0]    acc [4];
  logic [ACC_W-1:0]    rem [4];
  logic [CNT_W-1:0]    cnt;
  logic [DW:0]         d;
  logic [SW-1:0]       slot;
  logic [DIV_CW-1:0]   divctr;
  logic                vpass;
  logic                load_out;

  logic [DW:0]         hpos, vpos;
  logic                hvalid, vvalid, last_d;
  logic [SW-1:0]       slot_inc;
  logic [MEM_AW-1:0]   waddr, raddr;
  logic [31:0]         win_rd, hres;

  assign pop = (state == S_IDLE) && !empty;

  // box position checks and ring stepping
  assign hpos     = {1'b0, cur.xq} + d;
  assign vpos     = {1'b0, cur.yo} + d;
  assign hvalid   = (hpos >= (DW+1)'(cur.rad)) &&
                    (hpos - (DW+1)'(cur.rad) < {1'b0, cur.wid});
  assign vvalid   = (vpos >= (DW+1)'(cur.rad)) &&
                    (vpos - (DW+1)'(cur.rad) < {1'b0, cur.hgt});
  assign last_d   = (d == (DW+1)'(cur.rad) + (DW+1)'(cur.rad));
  assign slot_inc = (slot == SW'(DEPTH - 1)) ? '0 : slot + SW'(1);
  assign win_rd   = win[slot[WIN_IW-1:0]];
  assign waddr    = MEM_AW'(int'(cur.hrow[WIN_IW-1:0]) * MAX_WIDTH + int'(cur.xq));
  assign raddr    = MEM_AW'(int'(slot[WIN_IW-1:0]) * MAX_WIDTH + int'(cur.xo));
  assign hres     = {acc[3][7:0], acc[2][7:0], acc[1][7:0], acc[0][7:0]};
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  // row window
  always_ff @(posedge clk) begin
    if (pop && head.wr_en) begin
      win[head.wr_slot[WIN_IW-1:0]] <= {head.alpha, head.blue, head.green, head.red};
    end
  end

  // line buffers
  always_ff @(posedge clk) begin
    if (state == S_HWR) mem[waddr] <= hres;
    if (state == S_VSUM && vvalid) rdata <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            if (head.h_en) state <= S_HSUM;
            else if (head.v_en) state <= S_VSUM;
          end
        end
        S_HSUM:  if (last_d) state <= S_DIV;
        S_DIV: begin
          if (divctr == DIV_CW'(ACC_W - 1)) state <= vpass ? S_OUT : S_HWR;
        end
        S_HWR:   state <= cur.v_en ? S_VSUM : S_IDLE;
        S_VSUM:  if (last_d) state <= S_VLAST;
        S_VLAST: state <= S_DIV;
        S_OUT:   if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: sums, counts and the restoring divider
  always_ff @(posedge clk) begin
    logic [ACC_W-1:0] t;
    case (state)
      S_IDLE: begin
        cur     <= head;
        d       <= '0;
        cnt     <= '0;
        rd_pend <= 1'b0;
        slot    <= head.h_en ? head.hlo : head.vlo;
        for (int c = 0; c < 4; c++) acc[c] <= '0;
      end
      S_HSUM: begin
        if (hvalid) begin
          cnt <= cnt + CNT_W'(1);
          for (int c = 0; c < 4; c++) acc[c] <= acc[c] + ACC_W'(win_rd[8*c +: 8]);
        end
        d      <= d + (DW+1)'(1);
        slot   <= slot_inc;
        vpass  <= 1'b0;
        divctr <= '0;
        for (int c = 0; c < 4; c++) rem[c] <= '0;
      end
      S_DIV: begin
        divctr <= divctr + DIV_CW'(1);
        for (int c = 0; c < 4; c++) begin
          t = {rem[c][ACC_W-2:0], acc[c][ACC_W-1]};
          if (t >= ACC_W'(cnt)) begin
            rem[c] <= t - ACC_W'(cnt);
            acc[c] <= {acc[c][ACC_W-2:0], 1'b1};
          end else begin
            rem[c] <= t;
            acc[c] <= {acc[c][ACC_W-2:0], 1'b0};
          end
        end
      end
      S_HWR: begin
        d       <= '0;
        cnt     <= '0;
        rd_pend <= 1'b0;
        slot    <= cur.vlo;
        for (int c = 0; c < 4; c++) acc[c] <= '0;
      end
      S_VSUM: begin
        rd_pend <= vvalid;
        if (vvalid) cnt <= cnt + CNT_W'(1);
        if (rd_pend) begin
          for (int c = 0; c < 4; c++) acc[c] <= acc[c] + ACC_W'(rdata[8*c +: 8]);
        end
        d    <= d + (DW+1)'(1);
        slot <= slot_inc;
      end
      S_VLAST: begin
        if (rd_pend) begin
          for (int c = 0; c < 4; c++) acc[c] <= acc[c] + ACC_W'(rdata[8*c +: 8]);
        end
        vpass  <= 1'b1;
        divctr <= '0;
        for (int c = 0; c < 4; c++) rem[c] <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red      <= acc[0][7:0];
      out_green    <= acc[1][7:0];
      out_blue     <= acc[2][7:0];
      out_alpha    <= acc[3][7:0];
      end_of_frame <= cur.eof;
    end
  end

endmodule

// ----- hdl/separable_box_blur_rgba.sv -----
// ----------------------------------------------------------------------------
// separable_box_blur_rgba
// Streaming two-pass box blur on RGBA8 pixels in raster order.
// ----------------------------------------------------------------------------
// Each used item takes one command slot; the back end then runs the horizontal
// pass (box sum, divider steps, line buffer write) and the vertical pass (box
// sum over the line buffers, divider steps, output) as the command asks, with
// A = 8 + clog2(2*MAX_RADIUS+2) divider steps (13 at the defaults). The back
// end has a single sequencer, a divider that takes one step per cycle and a
// single read port on the line buffers, and takes no new command until the
// last one is done. A four-entry command queue lets the input run ahead;
// ignored early flush items are not queued. Output pixel o leaves for item
// o + r*width + r; after the last pixel of a frame, flush items drain the rest. Line buffers need no clearing pass.
module separable_box_blur_rgba #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic [7:0]                alpha,
  input  logic                      flush,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic                      end_of_frame,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [sbb_pkg::DIM_W-1:0] cfg_data
);

  logic          q_push, q_pop, q_full, q_empty;
  sbb_pkg::cmd_t q_in, q_head;

  sbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .flush      (flush),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .queue_full (q_full),
    .in_stall   (in_stall),
    .push       (q_push),
    .cmd        (q_in),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .end_of_frame (end_of_frame)
  );

  // queue is never written when full nor read when empty
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("command pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("command popped from empty queue");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty)) else $error("queue both full and empty");

endmodule

// ----- sim/separable_box_blur_rgba_tb.sv -----
// ----------------------------------------------------------------------------
// separable_box_blur_rgba_tb
// Self-checking bench for the streaming RGBA box blur. Whole frames are
// streamed and drained with flush items. A behavioral blur predicts each
// output pixel as input items are accepted, and every output is compared
// in order. Geometry is changed between frames, including out-of-range
// values that the block clamps. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module separable_box_blur_rgba_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW   = 1024;
  localparam int MAXH   = 1024;
  localparam int MAXR   = 8;
  localparam int WDEPTH = 2 * MAXR + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       eof;
  } blur_px_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                red = '0, green = '0, blue = '0, alpha = '0;
  logic                      flush = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                out_red, out_green, out_blue, out_alpha;
  logic                      end_of_frame;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = sbb_pkg::REG_WIDTH;
  logic [sbb_pkg::DIM_W-1:0] cfg_data = '0;

  separable_box_blur_rgba dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: own copy of geometry, pixel window and line buffers
  logic [sbb_pkg::DIM_W-1:0] geo_width  = 11'd640;
  logic [sbb_pkg::DIM_W-1:0] geo_height = 11'd480;
  logic [sbb_pkg::RAD_W-1:0] geo_radius = 4'd1;
  logic [31:0]      pix_window [WDEPTH];
  logic [31:0]      hblur_rows [WDEPTH][MAXW];
  int unsigned      frame_items;
  bit               frame_done;
  bit               draining;

  blur_px_t expected_px[$];
  int       errors;
  int       pixel_count;      // pixel-carrying items that the block used
  int       send_idle_pct;
  int       stall_pct;
  int       hold_token, hold_seen, hold_left;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [31:0] box_avg(int unsigned sum[4], int unsigned cnt);
    logic [31:0] px;
    for (int c = 0; c < 4; c++) px[8*c +: 8] = 8'(sum[c] / cnt);
    return px;
  endfunction

  // Predict one accepted item; pushes an expected pixel when one is due
  task automatic blur_predict(input logic [31:0] pix, input logic fl);
    int unsigned w, h, rad, total, dly, n, q, xq, yq, o, xo, yo, cnt, nx, ny;
    int unsigned sum[4];
    logic [31:0] px;
    blur_px_t    e;
    w = clampu(geo_width, 1, MAXW);
    h = clampu(geo_height, 1, MAXH);
    rad = clampu(geo_radius, 1, MAXR);
    total = w * h;
    dly = rad * w + rad;
    n = frame_items;
    if (n < total) begin
      if (fl) return;
      pix_window[n % WDEPTH] = pix;
      pixel_count++;
    end
    // horizontal pass for the pixel rad items back
    if (n >= rad && n - rad < total) begin
      q = n - rad;
      xq = q % w;
      yq = q / w;
      sum = '{default: 0};
      cnt = 0;
      for (int unsigned d = 0; d <= 2 * rad; d++) begin
        nx = xq + d;
        if (nx < rad || nx - rad >= w) continue;
        px = pix_window[(q + d - rad) % WDEPTH];
        for (int c = 0; c < 4; c++) sum[c] += px[8*c +: 8];
        cnt++;
      end
      hblur_rows[yq % WDEPTH][xq] = box_avg(sum, cnt);
    end
    frame_items = n + 1;
    draining = (frame_items >= total);
    // vertical pass for the pixel leaving now
    if (n >= dly) begin
      o = n - dly;
      xo = o % w;
      yo = o / w;
      sum = '{default: 0};
      cnt = 0;
      for (int unsigned d = 0; d <= 2 * rad; d++) begin
        ny = yo + d;
        if (ny < rad || ny - rad >= h) continue;
        px = hblur_rows[(ny - rad) % WDEPTH][xo];
        for (int c = 0; c < 4; c++) sum[c] += px[8*c +: 8];
        cnt++;
      end
      px = box_avg(sum, cnt);
      e.red = px[7:0];
      e.green = px[15:8];
      e.blue = px[23:16];
      e.alpha = px[31:24];
      e.eof = (o + 1 >= total);
      expected_px.push_back(e);
      if (e.eof) begin
        frame_items = 0;
        frame_done = 1'b1;
        draining = 1'b0;
      end
    end
  endtask

  // Send one item and wait until it is taken
  task automatic send_item(input logic [31:0] pix, input logic fl);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= pix[7:0];
    green <= pix[15:8];
    blue <= pix[23:16];
    alpha <= pix[31:24];
    flush <= fl;
    do @(posedge clk); while (in_stall);
    blur_predict(pix, fl);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Wait for all expected pixels, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    flush <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Drive one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [sbb_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sbb_pkg::REG_WIDTH:  geo_width = val;
      sbb_pkg::REG_HEIGHT: geo_height = val;
      sbb_pkg::REG_RADIUS: geo_radius = val[sbb_pkg::RAD_W-1:0];
      default: ;
    endcase
    frame_items = 0;
    draining = 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int r);
    wait_idle();
    write_reg(sbb_pkg::REG_WIDTH, sbb_pkg::DIM_W'(w));
    write_reg(sbb_pkg::REG_HEIGHT, sbb_pkg::DIM_W'(h));
    write_reg(sbb_pkg::REG_RADIUS, sbb_pkg::DIM_W'(r));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stream one frame: pixels with stray early flushes, then drain ticks
  task automatic run_frame(input int early_pct);
    logic [31:0] pix;
    frame_done = 1'b0;
    while (!frame_done) begin
      pix = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
      if (draining) send_item(pix, ($urandom_range(9) != 0));
      else send_item(pix, ($urandom_range(99) < early_pct));
    end
  endtask

  // Result check
  always @(posedge clk) begin
    blur_px_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output pixel %h %h %h %h eof=%b",
                                   out_red, out_green, out_blue, out_alpha, end_of_frame);
      end else begin
        e = expected_px.pop_front();
        if (out_red !== e.red || out_green !== e.green || out_blue !== e.blue ||
            out_alpha !== e.alpha || end_of_frame !== e.eof) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: exp %h %h %h %h eof=%b got %h %h %h %h eof=%b",
                     e.red, e.green, e.blue, e.alpha, e.eof,
                     out_red, out_green, out_blue, out_alpha, end_of_frame);
        end
      end
    end
  end

  // Output stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    set_geometry(3, 2, 1);
    run_frame(25);
    set_geometry(4, 3, 2);
    run_frame(10);
  endtask

  task automatic test_register_clamps();
    set_geometry(0, 0, 0);          // clamps to a single pixel, radius one
    run_frame(30);
    set_geometry(5, 4, 15);         // radius clamps to the maximum
    run_frame(0);
    set_geometry(1, 2047, 8);       // tallest column
    run_frame(0);
  endtask

  task automatic test_random(input int idle_pct, input int st_pct, input int target);
    int start;
    send_idle_pct = idle_pct;
    stall_pct = st_pct;
    start = pixel_count;
    while (pixel_count - start < target) begin
      if ($urandom_range(3) == 0)
        set_geometry($urandom_range(12, 0), $urandom_range(8, 0), $urandom_range(15));
      else
        set_geometry($urandom_range(10, 1), $urandom_range(6, 1), $urandom_range(4, 1));
      run_frame(8);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_geometry(6, 6, 2);
    hold_token++;
    run_frame(0);
  endtask

  initial begin
    errors = 0;
    pixel_count = 0;
    hold_token = 0;
    hold_seen = 0;
    frame_items = 0;
    frame_done = 1'b0;
    draining = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_clamps();
    test_random(0, 0, 100);
    test_random(51, 0, 100);
    test_random(0, 51, 100);
    test_random(11, 11, 100);
    test_backpressure();
    wait_idle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sbb_pkg.sv
hdl/sbb_front.sv
hdl/sbb_queue.sv
hdl/sbb_back.sv
hdl/separable_box_blur_rgba.sv
sim/separable_box_blur_rgba_tb.sv
